// File: src/agfdl_pkg.sv
package agfdl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 7;
    localparam int PROD_W   = 23;   // sample * volume, |x| <= 3276800
    localparam int LEVEL_W  = 18;   // gain and filter values, -65536..65534
    localparam int NUM_W    = 25;   // 85*s + 15*acc, |x| <= 6553600
    localparam int DITHER_W = 7;    // -63..63
    localparam int NOISE_W  = 32;
    localparam int CODE_W   = 8;

    localparam logic [VOL_W-1:0] VOL_UNITY = 7'd50;
    localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;

    // Exact truncating division by reciprocal multiply:
    // q = (x * MULT) >> SHIFT for every x below 2^MAG_W.
    localparam int               DIV50_MAG_W  = 22;
    localparam int               DIV50_SHIFT  = 28;
    localparam logic [22:0]      DIV50_MULT   = 23'd5368710;
    localparam int               DIV100_MAG_W = 23;
    localparam int               DIV100_SHIFT = 30;
    localparam logic [23:0]      DIV100_MULT  = 24'd10737419;
    localparam int               QUOT_W       = 17;

    localparam logic signed [NUM_W-1:0] COEF_NEW = 25'sd85;
    localparam logic signed [NUM_W-1:0] COEF_OLD = 25'sd15;

    localparam logic [NOISE_W-1:0] NOISE_SEED  = 32'hDEADBEEF;
    localparam int                 DITHER_BITS = 6;

    localparam logic signed [LEVEL_W-1:0] KNEE     = 18'sd24576;
    localparam logic signed [LEVEL_W-1:0] CLAMP_HI = 18'sd32767;
    localparam logic signed [LEVEL_W-1:0] CLAMP_LO = -18'sd32768;

    // one step of the 13/17/5 xorshift generator
    function automatic logic [NOISE_W-1:0] xorshift_step(input logic [NOISE_W-1:0] x);
        logic [NOISE_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

// File: src/audio_gain_filter_dither_limiter.sv
// Audio output path: volume gain (volume/50, writes above 100 saturate to 100, reset 50),
// one-pole low-pass acc = (85*s + 15*acc)/100, triangular dither of -63..63 from a
// 32-bit xorshift generator stepped twice per sample, 4:1 soft limiter beyond +-24576,
// clamp to 16 bits, and an 8-bit offset-binary DAC code. One sample is taken every
// clock cycle unless dac_stall has backed the pipeline up; a code passes the input,
// product, gain, filter and output registers after its sample is accepted. The rate
// is set by the filter accumulator, which is updated once per accepted sample. Write
// the volume only while no samples are in flight.
module audio_gain_filter_dither_limiter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  volume_we,
    input  logic [agfdl_pkg::VOL_W-1:0]           volume_wdata,
    input  logic signed [agfdl_pkg::SAMPLE_W-1:0] apu_sample,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    output logic [agfdl_pkg::CODE_W-1:0]          dac_code,
    output logic                                  dac_valid,
    input  logic                                  dac_stall
);
    import agfdl_pkg::*;

    logic                       sample_ready;
    logic signed [LEVEL_W-1:0]  level;
    logic                       level_valid;
    logic                       level_ready;
    logic signed [LEVEL_W-1:0]  acc;
    logic signed [DITHER_W-1:0] dither;
    logic                       acc_valid;
    logic                       acc_ready;

    agfdl_gain u_gain
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .volume_we    (volume_we),
        .volume_wdata (volume_wdata),
        .sample       (apu_sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .level        (level),
        .level_valid  (level_valid),
        .level_ready  (level_ready)
    );

    agfdl_filter u_filter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .level       (level),
        .level_valid (level_valid),
        .level_ready (level_ready),
        .acc         (acc),
        .dither      (dither),
        .acc_valid   (acc_valid),
        .acc_ready   (acc_ready)
    );

    agfdl_limiter u_limiter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .dither     (dither),
        .acc_valid  (acc_valid),
        .acc_ready  (acc_ready),
        .code       (dac_code),
        .code_valid (dac_valid),
        .code_ready (!dac_stall)
    );

    assign sample_stall = !sample_ready;

    // an empty output register means every stage can move
    assert property (@(posedge clk) disable iff (!rst_n) !dac_valid |-> !sample_stall)
        else $error("input stalled with output register empty");

    // the filter accumulator never leaves its bounded range
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc >= -18'sd65536) && (acc <= 18'sd65534))
        else $error("filter accumulator out of range");

    // a stalled output word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        dac_valid && dac_stall |=> dac_valid && $stable(dac_code))
        else $error("stalled output word changed");

endmodule

// File: src/agfdl_gain.sv
module agfdl_gain
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  volume_we,
    input  logic [agfdl_pkg::VOL_W-1:0]           volume_wdata,
    input  logic signed [agfdl_pkg::SAMPLE_W-1:0] sample,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    output logic signed [agfdl_pkg::LEVEL_W-1:0]  level,
    output logic                                  level_valid,
    input  logic                                  level_ready
);
    import agfdl_pkg::*;

    logic [VOL_W-1:0]           volume_reg;
    logic [VOL_W-1:0]           volume_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       sample_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       prod_valid_reg;
    logic signed [LEVEL_W-1:0]  level_reg;
    logic signed [LEVEL_W-1:0]  level_next;
    logic                       level_valid_reg;

    logic                       ready_s1;
    logic                       ready_s2;
    logic                       ready_s3;

    logic [PROD_W-1:0]          prod_abs;
    logic [DIV50_MAG_W-1:0]     prod_mag;
    logic [DIV50_MAG_W+22:0]    prod_scaled;
    logic [QUOT_W-1:0]          quot;

    // volumes above full scale saturate on write
    assign volume_next = (volume_wdata > VOL_MAX) ? VOL_MAX : volume_wdata;

    assign ready_s3     = !level_valid_reg || level_ready;
    assign ready_s2     = !prod_valid_reg || ready_s3;
    assign ready_s1     = !sample_valid_reg || ready_s2;
    assign sample_ready = ready_s1;

    assign prod_next = PROD_W'(sample_reg) * PROD_W'($signed({1'b0, volume_reg}));

    // divide by 50, truncating toward zero
    assign prod_abs    = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign prod_mag    = prod_abs[DIV50_MAG_W-1:0];
    assign prod_scaled = (DIV50_MAG_W+23)'(prod_mag) * (DIV50_MAG_W+23)'(DIV50_MULT);
    assign quot        = prod_scaled[DIV50_SHIFT +: QUOT_W];
    assign level_next  = prod_reg[PROD_W-1] ? -$signed(LEVEL_W'({1'b0, quot}))
                                            : $signed(LEVEL_W'({1'b0, quot}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg       <= VOL_UNITY;
            sample_valid_reg <= 1'b0;
            prod_valid_reg   <= 1'b0;
            level_valid_reg  <= 1'b0;
        end
        else
        begin
            if (volume_we)
            begin
                volume_reg <= volume_next;
            end
            if (ready_s1)
            begin
                sample_valid_reg <= sample_valid;
            end
            if (ready_s2)
            begin
                prod_valid_reg <= sample_valid_reg;
            end
            if (ready_s3)
            begin
                level_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_s1 && sample_valid)
        begin
            sample_reg <= sample;
        end
        if (ready_s2 && sample_valid_reg)
        begin
            prod_reg <= prod_next;
        end
        if (ready_s3 && prod_valid_reg)
        begin
            level_reg <= level_next;
        end
    end

    assign level       = level_reg;
    assign level_valid = level_valid_reg;

endmodule

// File: src/agfdl_filter.sv
module agfdl_filter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [agfdl_pkg::LEVEL_W-1:0]  level,
    input  logic                                  level_valid,
    output logic                                  level_ready,
    output logic signed [agfdl_pkg::LEVEL_W-1:0]  acc,
    output logic signed [agfdl_pkg::DITHER_W-1:0] dither,
    output logic                                  acc_valid,
    input  logic                                  acc_ready
);
    import agfdl_pkg::*;

    logic signed [LEVEL_W-1:0]   acc_reg;
    logic signed [LEVEL_W-1:0]   acc_next;
    logic [NOISE_W-1:0]          noise_reg;
    logic [NOISE_W-1:0]          noise_mid;
    logic [NOISE_W-1:0]          noise_next;
    logic signed [DITHER_W-1:0]  dither_reg;
    logic signed [DITHER_W-1:0]  dither_next;
    logic                        valid_reg;
    logic                        load;

    logic signed [NUM_W-1:0]     num;
    logic [NUM_W-1:0]            num_abs;
    logic [DIV100_MAG_W-1:0]     num_mag;
    logic [DIV100_MAG_W+23:0]    num_scaled;
    logic [QUOT_W-1:0]           quot;

    assign level_ready = !valid_reg || acc_ready;
    assign load        = level_ready && level_valid;

    // acc = (85*s + 15*acc) / 100, truncating toward zero
    assign num        = NUM_W'(level) * COEF_NEW + NUM_W'(acc_reg) * COEF_OLD;
    assign num_abs    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign num_mag    = num_abs[DIV100_MAG_W-1:0];
    assign num_scaled = (DIV100_MAG_W+24)'(num_mag) * (DIV100_MAG_W+24)'(DIV100_MULT);
    assign quot       = num_scaled[DIV100_SHIFT +: QUOT_W];
    assign acc_next   = num[NUM_W-1] ? -$signed(LEVEL_W'({1'b0, quot}))
                                     : $signed(LEVEL_W'({1'b0, quot}));

    // two generator steps per word give triangular dither
    assign noise_mid   = xorshift_step(noise_reg);
    assign noise_next  = xorshift_step(noise_mid);
    assign dither_next = $signed(DITHER_W'({1'b0, noise_mid[DITHER_BITS-1:0]}))
                       - $signed(DITHER_W'({1'b0, noise_next[DITHER_BITS-1:0]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
            noise_reg <= NOISE_SEED;
        end
        else
        begin
            if (level_ready)
            begin
                valid_reg <= level_valid;
            end
            if (load)
            begin
                acc_reg   <= acc_next;
                noise_reg <= noise_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dither_reg <= dither_next;
        end
    end

    assign acc       = acc_reg;
    assign dither    = dither_reg;
    assign acc_valid = valid_reg;

endmodule

// File: src/agfdl_limiter.sv
module agfdl_limiter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [agfdl_pkg::LEVEL_W-1:0]  acc,
    input  logic signed [agfdl_pkg::DITHER_W-1:0] dither,
    input  logic                                  acc_valid,
    output logic                                  acc_ready,
    output logic [agfdl_pkg::CODE_W-1:0]          code,
    output logic                                  code_valid,
    input  logic                                  code_ready
);
    import agfdl_pkg::*;

    logic signed [LEVEL_W-1:0] mixed;
    logic signed [LEVEL_W-1:0] limited;
    logic signed [LEVEL_W-1:0] clamped;
    logic [CODE_W-1:0]         code_reg;
    logic [CODE_W-1:0]         code_next;
    logic                      valid_reg;

    assign acc_ready = !valid_reg || code_ready;

    assign mixed = acc + LEVEL_W'(dither);

    // 4:1 compression beyond the knee, truncating toward zero on both sides
    always_comb
    begin
        priority if (mixed > KNEE)
        begin
            limited = KNEE + ((mixed - KNEE) >>> 2);
        end
        else if (mixed < -KNEE)
        begin
            limited = -KNEE - ((-(mixed + KNEE)) >>> 2);
        end
        else
        begin
            limited = mixed;
        end
    end

    always_comb
    begin
        priority if (limited > CLAMP_HI)
        begin
            clamped = CLAMP_HI;
        end
        else if (limited < CLAMP_LO)
        begin
            clamped = CLAMP_LO;
        end
        else
        begin
            clamped = limited;
        end
    end

    // top byte of s + 0x8000: flip the sign bit
    assign code_next = {~clamped[SAMPLE_W-1], clamped[SAMPLE_W-2:SAMPLE_W-CODE_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (acc_ready)
        begin
            valid_reg <= acc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_ready && acc_valid)
        begin
            code_reg <= code_next;
        end
    end

    assign code       = code_reg;
    assign code_valid = valid_reg;

endmodule
